@@ rtl/core/pfu_pkg.sv @@
// Shared constants and types for the particle field update core.
// Holds register index codes, reset values and the fade quotient width.
// No dependencies.
package pfu_pkg;

  // Configuration register index.
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIELD_ENABLE = 2'd0,
    CFG_BOX_MIN      = 2'd1,
    CFG_BOX_MAX      = 2'd2,
    CFG_ACCEL_STEP   = 2'd3
  } cfg_reg_e;

  // Reset values, packed z,y,x with x lowest.
  localparam logic        RST_FIELD_ENABLE = 1'b1;
  localparam logic [47:0] RST_BOX_MIN      = 48'hFF00_FF00_FF00;
  localparam logic [47:0] RST_BOX_MAX      = 48'h0100_0101_0100;
  localparam logic [47:0] RST_ACCEL_STEP   = 48'h0000_0000_0001;

  // Fade value width and divider organisation (two quotient bits per stage).
  localparam int unsigned ALPHA_W        = 8;
  localparam int unsigned BITS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES     = ALPHA_W / BITS_PER_STAGE;

endpackage

@@ rtl/core/pfu_if.sv @@
// Valid/ready stream interfaces for particle items and updated particles.
// Widths follow the coordinate and age widths of the instantiating block.
// No dependencies.
interface pfu_in_if #(
  parameter int unsigned CW = 16,
  parameter int unsigned AW = 10
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic signed [CW-1:0] vel_x;
  logic signed [CW-1:0] vel_y;
  logic signed [CW-1:0] vel_z;
  logic [AW-1:0]        age;
  logic [AW-1:0]        life;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, age, life,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, age, life,
    output ready
  );
endinterface

interface pfu_out_if #(
  parameter int unsigned CW = 16,
  parameter int unsigned AW = 10
) ();
  logic                 valid;
  logic                 ready;
  logic                 alive;
  logic signed [CW-1:0] new_pos_x;
  logic signed [CW-1:0] new_pos_y;
  logic signed [CW-1:0] new_pos_z;
  logic signed [CW-1:0] new_vel_x;
  logic signed [CW-1:0] new_vel_y;
  logic signed [CW-1:0] new_vel_z;
  logic [AW-1:0]        new_age;
  logic [7:0]           alpha;

  modport source (
    output valid, alive, new_pos_x, new_pos_y, new_pos_z,
           new_vel_x, new_vel_y, new_vel_z, new_age, alpha,
    input  ready
  );
  modport sink (
    input  valid, alive, new_pos_x, new_pos_y, new_pos_z,
           new_vel_x, new_vel_y, new_vel_z, new_age, alpha,
    output ready
  );
endinterface

@@ rtl/core/pfu_cfg_regs.sv @@
// Configuration register file of the particle field update core.
// Depends on pfu_pkg for register indexes and reset values.
module pfu_cfg_regs #(
  parameter int unsigned CW = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pfu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [3*CW-1:0]                 cfg_wdata_i,
  output logic                            field_en_o,
  output logic [3*CW-1:0]                 box_min_o,
  output logic [3*CW-1:0]                 box_max_o,
  output logic [3*CW-1:0]                 accel_o
);
  localparam int unsigned CfgW = 3 * CW;

  logic            field_en_q;
  logic [CfgW-1:0] box_min_q;
  logic [CfgW-1:0] box_max_q;
  logic [CfgW-1:0] accel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_en_q <= pfu_pkg::RST_FIELD_ENABLE;
      box_min_q  <= CfgW'(pfu_pkg::RST_BOX_MIN);
      box_max_q  <= CfgW'(pfu_pkg::RST_BOX_MAX);
      accel_q    <= CfgW'(pfu_pkg::RST_ACCEL_STEP);
    end else if (cfg_we_i) begin
      unique case (pfu_pkg::cfg_reg_e'(cfg_idx_i))
        pfu_pkg::CFG_FIELD_ENABLE: field_en_q <= cfg_wdata_i[0];
        pfu_pkg::CFG_BOX_MIN:      box_min_q  <= cfg_wdata_i;
        pfu_pkg::CFG_BOX_MAX:      box_max_q  <= cfg_wdata_i;
        pfu_pkg::CFG_ACCEL_STEP:   accel_q    <= cfg_wdata_i;
      endcase
    end
  end

  assign field_en_o = field_en_q;
  assign box_min_o  = box_min_q;
  assign box_max_o  = box_max_q;
  assign accel_o    = accel_q;
endmodule

@@ rtl/core/pfu_kin.sv @@
// Two-stage kinematics front end: expiry test, box field and velocity
// update, then position update and fade numerator. Depends on pfu_pkg.
module pfu_kin #(
  parameter int unsigned CW = 16,
  parameter int unsigned AW = 10
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [3*CW-1:0]                      pos_i,
  input  logic [3*CW-1:0]                      vel_i,
  input  logic [AW-1:0]                        age_i,
  input  logic [AW-1:0]                        life_i,
  input  logic                                 field_en_i,
  input  logic [3*CW-1:0]                      box_min_i,
  input  logic [3*CW-1:0]                      box_max_i,
  input  logic [3*CW-1:0]                      accel_i,
  output logic                                 valid_o,
  output logic                                 alive_o,
  output logic [3*CW-1:0]                      pos_o,
  output logic [3*CW-1:0]                      vel_o,
  output logic [AW-1:0]                        age_o,
  output logic [AW-1:0]                        life_o,
  output logic [AW+pfu_pkg::ALPHA_W-1:0]       num_o
);
  localparam int unsigned NW = AW + pfu_pkg::ALPHA_W;

  function automatic logic signed [CW-1:0] sat_add(
    input logic signed [CW-1:0] a,
    input logic signed [CW-1:0] b
  );
    logic signed [CW:0] s;
    s = {a[CW-1], a} + {b[CW-1], b};
    if (s[CW] != s[CW-1]) begin
      sat_add = s[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      sat_add = s[CW-1:0];
    end
  endfunction

  // Stage 1: expiry, box test, velocity
  logic            dead;
  logic            in_box;
  logic            apply;
  logic [3*CW-1:0] vel1_d;
  logic [AW-1:0]   age1_d;

  always_comb begin
    dead   = (age_i >= life_i);
    in_box = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if ($signed(pos_i[k*CW +: CW]) < $signed(box_min_i[k*CW +: CW]) ||
          $signed(pos_i[k*CW +: CW]) > $signed(box_max_i[k*CW +: CW])) begin
        in_box = 1'b0;
      end
    end
    apply = field_en_i && in_box && !dead;
    for (int k = 0; k < 3; k++) begin
      vel1_d[k*CW +: CW] = apply ? sat_add(vel_i[k*CW +: CW], accel_i[k*CW +: CW])
                                 : vel_i[k*CW +: CW];
    end
    age1_d = dead ? age_i : age_i + AW'(1);
  end

  logic            v1_q;
  logic            alive1_q;
  logic [3*CW-1:0] pos1_q;
  logic [3*CW-1:0] vel1_q;
  logic [AW-1:0]   age1_q;
  logic [AW-1:0]   life1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      alive1_q <= !dead;
      pos1_q   <= pos_i;
      vel1_q   <= vel1_d;
      age1_q   <= age1_d;
      life1_q  <= life_i;
    end
  end

  // Stage 2: position and fade numerator 255 * age
  logic [3*CW-1:0] pos2_d;
  logic [NW-1:0]   num2_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos2_d[k*CW +: CW] = alive1_q ? sat_add(pos1_q[k*CW +: CW], vel1_q[k*CW +: CW])
                                    : pos1_q[k*CW +: CW];
    end
    num2_d = {age1_q, {pfu_pkg::ALPHA_W{1'b0}}} - NW'(age1_q);
  end

  logic            v2_q;
  logic            alive2_q;
  logic [3*CW-1:0] pos2_q;
  logic [3*CW-1:0] vel2_q;
  logic [AW-1:0]   age2_q;
  logic [AW-1:0]   life2_q;
  logic [NW-1:0]   num2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      alive2_q <= alive1_q;
      pos2_q   <= pos2_d;
      vel2_q   <= vel1_q;
      age2_q   <= age1_q;
      life2_q  <= life1_q;
      num2_q   <= num2_d;
    end
  end

  assign valid_o = v2_q;
  assign alive_o = alive2_q;
  assign pos_o   = pos2_q;
  assign vel_o   = vel2_q;
  assign age_o   = age2_q;
  assign life_o  = life2_q;
  assign num_o   = num2_q;
endmodule

@@ rtl/core/pfu_div_step.sv @@
// One pipelined restoring-division stage: resolves two quotient bits of
// the fade ratio and carries the particle payload alongside. Uses pfu_pkg.
module pfu_div_step #(
  parameter int unsigned AW     = 10,
  parameter int unsigned HI     = 7,
  parameter int unsigned PASS_W = 107
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [AW+pfu_pkg::ALPHA_W-1:0]      rem_i,
  input  logic [AW-1:0]                       life_i,
  input  logic [pfu_pkg::ALPHA_W-1:0]         quo_i,
  input  logic [PASS_W-1:0]                   pass_i,
  output logic                                valid_o,
  output logic [AW+pfu_pkg::ALPHA_W-1:0]      rem_o,
  output logic [AW-1:0]                       life_o,
  output logic [pfu_pkg::ALPHA_W-1:0]         quo_o,
  output logic [PASS_W-1:0]                   pass_o
);
  localparam int unsigned NW = AW + pfu_pkg::ALPHA_W;
  localparam int unsigned LO = HI - 1;

  logic [NW-1:0]                 dv_hi;
  logic [NW-1:0]                 dv_lo;
  logic [NW-1:0]                 rem_mid;
  logic [NW-1:0]                 rem_d;
  logic [pfu_pkg::ALPHA_W-1:0]   quo_d;

  always_comb begin
    dv_hi   = NW'(life_i) << HI;
    dv_lo   = NW'(life_i) << LO;
    quo_d   = quo_i;
    rem_mid = rem_i;
    if (rem_i >= dv_hi) begin
      rem_mid   = rem_i - dv_hi;
      quo_d[HI] = 1'b1;
    end
    rem_d = rem_mid;
    if (rem_mid >= dv_lo) begin
      rem_d     = rem_mid - dv_lo;
      quo_d[LO] = 1'b1;
    end
  end

  logic                          v_q;
  logic [NW-1:0]                 rem_q;
  logic [AW-1:0]                 life_q;
  logic [pfu_pkg::ALPHA_W-1:0]   quo_q;
  logic [PASS_W-1:0]             pass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      life_q <= life_i;
      quo_q  <= quo_d;
      pass_q <= pass_i;
    end
  end

  assign valid_o = v_q;
  assign rem_o   = rem_q;
  assign life_o  = life_q;
  assign quo_o   = quo_q;
  assign pass_o  = pass_q;
endmodule

@@ rtl/core/particle_field_update_core.sv @@
// Advances one particle per transaction by one frame: optional box field on
// velocity, saturating Euler step on position, age increment and fade alpha.
// Accepts one particle every cycle unless the output stalls; the result goes
// through the two kinematics stages and the four radix-4 stages of the
// 255*age/life divider. The whole pipeline holds while a finished result
// waits at the output. Depends on pfu_pkg, pfu_if, pfu_cfg_regs, pfu_kin and
// pfu_div_step.
module particle_field_update_core #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned AGE_WIDTH   = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pfu_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [3*COORD_WIDTH-1:0]            cfg_wdata_i,
  pfu_in_if.sink                              in_i,
  pfu_out_if.source                           out_o
);
  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned AW     = AGE_WIDTH;
  localparam int unsigned QW     = pfu_pkg::ALPHA_W;
  localparam int unsigned NW     = AW + QW;
  localparam int unsigned NST    = pfu_pkg::DIV_STAGES;
  localparam int unsigned PASS_W = 1 + 6 * CW + AW;

  logic            field_en;
  logic [3*CW-1:0] box_min;
  logic [3*CW-1:0] box_max;
  logic [3*CW-1:0] accel;

  pfu_cfg_regs #(.CW(CW)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .field_en_o  (field_en),
    .box_min_o   (box_min),
    .box_max_o   (box_max),
    .accel_o     (accel)
  );

  // Advance every stage together unless the output holds an untaken result.
  logic adv;
  logic [NST:0] v_s;

  assign adv       = !v_s[NST] || out_o.ready;
  assign in_i.ready = adv;

  logic            k_alive;
  logic [3*CW-1:0] k_pos;
  logic [3*CW-1:0] k_vel;
  logic [AW-1:0]   k_age;

  logic [NW-1:0]     rem_s  [NST+1];
  logic [AW-1:0]     life_s [NST+1];
  logic [QW-1:0]     quo_s  [NST+1];
  logic [PASS_W-1:0] pass_s [NST+1];

  pfu_kin #(.CW(CW), .AW(AW)) u_kin (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (in_i.valid),
    .pos_i      ({in_i.pos_z, in_i.pos_y, in_i.pos_x}),
    .vel_i      ({in_i.vel_z, in_i.vel_y, in_i.vel_x}),
    .age_i      (in_i.age),
    .life_i     (in_i.life),
    .field_en_i (field_en),
    .box_min_i  (box_min),
    .box_max_i  (box_max),
    .accel_i    (accel),
    .valid_o    (v_s[0]),
    .alive_o    (k_alive),
    .pos_o      (k_pos),
    .vel_o      (k_vel),
    .age_o      (k_age),
    .life_o     (life_s[0]),
    .num_o      (rem_s[0])
  );

  assign quo_s[0]  = '0;
  assign pass_s[0] = {k_alive, k_pos, k_vel, k_age};

  for (genvar g = 0; g < NST; g++) begin : g_div
    pfu_div_step #(
      .AW     (AW),
      .HI     (QW - 1 - pfu_pkg::BITS_PER_STAGE * g),
      .PASS_W (PASS_W)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (v_s[g]),
      .rem_i   (rem_s[g]),
      .life_i  (life_s[g]),
      .quo_i   (quo_s[g]),
      .pass_i  (pass_s[g]),
      .valid_o (v_s[g+1]),
      .rem_o   (rem_s[g+1]),
      .life_o  (life_s[g+1]),
      .quo_o   (quo_s[g+1]),
      .pass_o  (pass_s[g+1])
    );
  end

  logic            o_alive;
  logic [3*CW-1:0] o_pos;
  logic [3*CW-1:0] o_vel;
  logic [AW-1:0]   o_age;

  assign {o_alive, o_pos, o_vel, o_age} = pass_s[NST];

  assign out_o.valid     = v_s[NST];
  assign out_o.alive     = o_alive;
  assign out_o.new_pos_x = o_pos[0 +: CW];
  assign out_o.new_pos_y = o_pos[CW +: CW];
  assign out_o.new_pos_z = o_pos[2*CW +: CW];
  assign out_o.new_vel_x = o_vel[0 +: CW];
  assign out_o.new_vel_y = o_vel[CW +: CW];
  assign out_o.new_vel_z = o_vel[2*CW +: CW];
  assign out_o.new_age   = o_age;
  // 255 - q is the bitwise complement of an 8-bit quotient; expired fades to 0.
  assign out_o.alpha     = o_alive ? ~quo_s[NST] : '0;
endmodule
